// ----- hdl/dwvs_pkg.sv -----
// Package for the deque with value search: operation codes, status codes, cell control.
package dwvs_pkg;

	// operation codes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
	localparam logic [2:0] OP_CONTAINS   = 3'd6;
	localparam logic [2:0] OP_REMOVE     = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic shift_right; // push front: take left neighbor, cell 0 takes the value
		logic shift_left;  // pop front: take right neighbor
		logic remove;      // cells at or after the first match take right neighbor
		logic push_back;   // cell at the occupancy index takes the value
	} cell_ctl_t;

endpackage

// ----- hdl/dwvs_cell.sv -----
// One storage cell of the deque: holds an entry, compares it and shifts with its neighbors.
module dwvs_cell import dwvs_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int OCC_W      = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [OCC_W-1:0]      occ,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic                  hit_in,
	output logic                  hit_out,
	output logic [DATA_WIDTH-1:0] entry
);

	localparam logic [OCC_W-1:0] MY_IDX = OCC_W'(IDX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  live;
	logic                  match;

	// compare against the search value; hit chain marks the first match and all after it
	assign live    = MY_IDX < occ;
	assign match   = live && (entry_q == value);
	assign hit_out = hit_in | match;
	assign entry   = entry_q;

	// entry update, one shift or write per command
	always_ff @(posedge clk) begin
		if (ctl.shift_right) begin
			entry_q <= prev_data;
		end else if (ctl.shift_left) begin
			entry_q <= next_data;
		end else if (ctl.remove && hit_out) begin
			entry_q <= next_data;
		end else if (ctl.push_back && occ == MY_IDX) begin
			entry_q <= value;
		end
	end

endmodule

// ----- hdl/deque_with_value_search_core.sv -----
// Top level of the deque with value search: command register, cell chain, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start in, busy out   | operation[2:0], value[31:0] signed
//  result   | done out (strobe)    | status[1:0], data[31:0] signed, found,
//           |                      | count[4:0], is_empty
//
// Each command is first registered; then, while busy is high, the cell chain compares
// every entry, ripples the first-match flag and shifts.
// The result is registered in the cycle after that and shown on done for one cycle only.
// No new command is taken while busy is high; results never wait, so nothing stalls.
// Reset clears occupancy and control; entries hold garbage until written.
module deque_with_value_search_core import dwvs_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] data,
	output logic               found,
	output logic [4:0]         count,
	output logic               is_empty
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	logic                  valid_s1;
	logic [2:0]            op_s1;
	logic [DATA_WIDTH-1:0] value_s1;
	logic [OCC_W-1:0]      occ_q;

	logic                  done_q;
	logic [1:0]            status_q;
	logic signed [31:0]    data_q;
	logic                  found_q;
	logic [4:0]            count_q;
	logic                  empty_q;

	logic                  accept;
	logic [DATA_WIDTH-1:0] value_dw;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic                  hit [DEPTH+1];
	cell_ctl_t             ctl;
	logic                  is_full;
	logic                  no_entries;
	logic                  hit_any;
	logic [OCC_W-1:0]      occ_next;
	logic [1:0]            status_next;
	logic [DATA_WIDTH-1:0] peek_raw;
	logic [IDX_W-1:0]      back_idx;
	logic                  peek_en;
	logic signed [63:0]    peek_ext;
	logic signed [63:0]    value_ext;

	assign accept = start && !busy;
	assign busy   = valid_s1;

	// value taken at DATA_WIDTH bits
	assign value_ext = 64'(value);
	assign value_dw  = value_ext[DATA_WIDTH-1:0];

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			value_s1 <= value_dw;
		end
	end

	assign is_full    = occ_q == FULL_OCC;
	assign no_entries = occ_q == '0;
	assign hit_any    = hit[DEPTH];

	// command to the cells
	always_comb begin
		ctl = '0;
		if (valid_s1) begin
			ctl.shift_right = (op_s1 == OP_PUSH_FRONT) && !is_full;
			ctl.push_back   = (op_s1 == OP_PUSH_BACK) && !is_full;
			ctl.shift_left  = (op_s1 == OP_POP_FRONT) && !no_entries;
			ctl.remove      = (op_s1 == OP_REMOVE);
		end
	end

	// cell chain
	assign hit[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d;
		logic [DATA_WIDTH-1:0] next_d;
		if (i == 0) begin : g_first
			assign prev_d = value_s1;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end
		dwvs_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.OCC_W      (OCC_W),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.value     (value_s1),
			.occ       (occ_q),
			.prev_data (prev_d),
			.next_data (next_d),
			.hit_in    (hit[i]),
			.hit_out   (hit[i+1]),
			.entry     (cell_data[i])
		);
	end

	// peek read, sign-extended then cut to the port
	assign back_idx = IDX_W'(occ_q - OCC_W'(1));
	always_comb begin
		peek_raw = cell_data[0];
		if (op_s1 == OP_PEEK_BACK) begin
			peek_raw = cell_data[back_idx];
		end
	end
	assign peek_ext = 64'(signed'(peek_raw));
	assign peek_en  = ((op_s1 == OP_PEEK_FRONT) || (op_s1 == OP_PEEK_BACK)) && !no_entries;

	// status and next occupancy
	always_comb begin
		status_next = ST_OK;
		occ_next    = occ_q;
		case (op_s1)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (is_full) begin
					status_next = ST_FULL;
				end else begin
					occ_next = occ_q + OCC_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (no_entries) begin
					status_next = ST_EMPTY;
				end else begin
					occ_next = occ_q - OCC_W'(1);
				end
			end
			OP_PEEK_FRONT, OP_PEEK_BACK: begin
				if (no_entries) begin
					status_next = ST_EMPTY;
				end
			end
			OP_CONTAINS: begin
				if (!hit_any) begin
					status_next = ST_NOT_FOUND;
				end
			end
			OP_REMOVE: begin
				if (hit_any) begin
					occ_next = occ_q - OCC_W'(1);
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	// occupancy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				occ_q <= occ_next;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_next;
			data_q   <= peek_en ? peek_ext[31:0] : '0;
			found_q  <= ((op_s1 == OP_CONTAINS) || (op_s1 == OP_REMOVE)) && hit_any;
			count_q  <= 5'(occ_next);
			empty_q  <= occ_next == '0;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data     = data_q;
	assign found    = found_q;
	assign count    = count_q;
	assign is_empty = empty_q;

	// checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("occupancy above depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("command without result");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transfer did not raise busy");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK)
		else $error("found with bad status");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl.shift_right, ctl.shift_left, ctl.remove, ctl.push_back}) <= 1)
		else $error("conflicting cell commands");

endmodule
